// ===== hw/rtl/cbs_pkg.sv =====
package cbs_pkg;

   localparam int DEF_CHANNELS      = 3;
   localparam int DEF_COUNT_MODULUS = 100;
   // Each diagonal counter occupies a fixed seven-bit slot in the result word.
   localparam int DIAG_W            = 7;

   typedef enum logic [2:0] {
      OP_NEW,
      OP_CHECK,
      OP_PASS,
      OP_OUT,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_MORE_CH,
      COND_AGAIN,
      COND_JUMP,
      COND_END
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_NEW   = 3'd0;
   localparam step_type STEP_CHECK = 3'd1;
   localparam step_type STEP_PASS  = 3'd2;
   localparam step_type STEP_OUT   = 3'd3;
   localparam step_type STEP_CLEAR = 3'd4;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_word_type;

   // Status the datapath reports to the sequencer for its jump decisions.
   typedef struct packed {
      logic more_ch;
      logic again;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic   active;
      op_type op;
   } seq_ctl_type;

   // Microprogram: visit each channel in two steps, close the pass, and repeat the pass after the first
   // one and while it produced a fresh release, up to the pass limit; a clear word jumps to the output.
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w = '{op: OP_OUT, cond: COND_END, target: STEP_OUT};
      unique case (step)
         STEP_NEW:   w = '{op: OP_NEW,   cond: COND_NEXT,    target: STEP_CHECK};
         STEP_CHECK: w = '{op: OP_CHECK, cond: COND_MORE_CH, target: STEP_NEW};
         STEP_PASS:  w = '{op: OP_PASS,  cond: COND_AGAIN,   target: STEP_NEW};
         STEP_OUT:   w = '{op: OP_OUT,   cond: COND_END,     target: STEP_OUT};
         STEP_CLEAR: w = '{op: OP_CLEAR, cond: COND_JUMP,    target: STEP_OUT};
         default:    w = '{op: OP_OUT,   cond: COND_END,     target: STEP_OUT};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/channel_barrier_sync_top.sv =====
// A word runs P channel passes (P from 2 to CHANNELS + 2) and then the output step;
// a clear word runs only the clear and output steps. A new word is stalled until the
// microcoded sequencer, which visits the channels one by one (two steps per channel
// plus one step per pass), is done. A finished result waits in the output register
// while the next word is accepted. Reset is synchronous: the counter matrix and the
// release, wait and request-history flags clear to zero, and no result is pending.
module channel_barrier_sync_top
   import cbs_pkg::*;
#(
   parameter int CHANNELS      = DEF_CHANNELS,
   parameter int COUNT_MODULUS = DEF_COUNT_MODULUS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_clear_all,
   input  logic [CHANNELS-1:0]          req_request_levels,
   input  logic [CHANNELS*CHANNELS-1:0] req_filter_masks,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHANNELS-1:0]          rsp_request_after,
   output logic [DIAG_W*CHANNELS-1:0]   rsp_own_counters
);

   localparam int CNT_W     = $clog2(COUNT_MODULUS);
   localparam int CH_W      = $clog2(CHANNELS);
   localparam int PASS_W    = $clog2(CHANNELS + 2);
   localparam int PASS_LAST = CHANNELS + 1;

   typedef logic [CNT_W-1:0] cnt_type;

   cnt_type                     mat_ff [CHANNELS][CHANNELS];
   cnt_type                     mat_in [CHANNELS][CHANNELS];
   logic [CHANNELS-1:0]         rel_ff, rel_in;
   logic [CHANNELS-1:0]         relb_ff, relb_in;
   logic [CHANNELS-1:0]         wait_ff, wait_in;
   logic [CHANNELS-1:0]         reqb_ff, reqb_in;
   logic [CHANNELS-1:0]         req_ff, req_in;
   logic [CHANNELS-1:0]         fresh_ff, fresh_in;
   logic [CHANNELS-1:0]         filt_ff [CHANNELS];
   logic [CHANNELS-1:0]         filt_in [CHANNELS];
   logic [CH_W-1:0]             ch_ff, ch_in;
   logic [PASS_W-1:0]           pass_ff, pass_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CHANNELS-1:0]         rsp_req_ff, rsp_req_in;
   logic [DIAG_W*CHANNELS-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic           accept;
   logic           ok;
   cnt_type        own_next;
   seq_status_type status;
   seq_ctl_type    ctl;

   function automatic cnt_type cnt_inc(input cnt_type v);
      return (v == CNT_W'(COUNT_MODULUS - 1)) ? '0 : v + CNT_W'(1);
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = ctl.active;

   always_comb begin
      status.more_ch  = (ch_ff != CH_W'(CHANNELS - 1));
      status.again    = ((pass_ff == '0) || |(rel_ff & ~relb_ff)) &&
                        (pass_ff != PASS_W'(PASS_LAST));
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   cbs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .start_clear (req_clear_all),
      .status      (status),
      .ctl         (ctl)
   );

   always_comb begin
      mat_in       = mat_ff;
      rel_in       = rel_ff;
      relb_in      = relb_ff;
      wait_in      = wait_ff;
      reqb_in      = reqb_ff;
      req_in       = req_ff;
      fresh_in     = fresh_ff;
      filt_in      = filt_ff;
      ch_in        = ch_ff;
      pass_in      = pass_ff;
      rsp_req_in   = rsp_req_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Release check for the visited channel: every filtered other channel's
      // diagonal must match the corresponding entry of this channel's row.
      ok = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
         if ((i != int'(ch_ff)) && filt_ff[ch_ff][i] && (mat_ff[ch_ff][i] != mat_ff[i][i])) begin
            ok = 1'b0;
         end
      end
      own_next = cnt_inc(mat_ff[ch_ff][ch_ff]);

      if (accept) begin
         for (int c = 0; c < CHANNELS; c++) begin
            filt_in[c]  = req_filter_masks[c*CHANNELS +: CHANNELS];
            // A channel with an empty filter drops its request, except on a clear word.
            req_in[c]   = req_request_levels[c] &&
                          (req_clear_all || (req_filter_masks[c*CHANNELS +: CHANNELS] != '0));
            fresh_in[c] = !wait_ff[c];
         end
         ch_in   = '0;
         pass_in = '0;
      end

      if (ctl.active) begin
         unique case (ctl.op)
            OP_NEW: begin
               wait_in[ch_ff] = req_ff[ch_ff];
               if (req_ff[ch_ff] && !reqb_ff[ch_ff]) begin
                  rel_in[ch_ff] = 1'b0;
                  for (int i = 0; i < CHANNELS; i++) begin
                     mat_in[ch_ff][i] = cnt_inc(mat_ff[i][i]);
                  end
               end
            end
            OP_CHECK: begin
               if (req_ff[ch_ff] && fresh_ff[ch_ff] && ok) begin
                  rel_in[ch_ff] = 1'b1;
                  if (!relb_ff[ch_ff]) begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        mat_in[ch_ff][i] = own_next;
                     end
                  end
               end
               ch_in = status.more_ch ? ch_ff + CH_W'(1) : '0;
            end
            OP_PASS: begin
               req_in   = req_ff & ~rel_ff;
               reqb_in  = req_ff & ~rel_ff;
               fresh_in = '1;
               relb_in  = rel_ff;
               if (pass_ff != PASS_W'(PASS_LAST)) begin
                  pass_in = pass_ff + PASS_W'(1);
               end
            end
            OP_OUT: begin
               if (status.out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_req_in   = req_ff;
                  for (int c = 0; c < CHANNELS; c++) begin
                     rsp_cnt_in[c*DIAG_W +: DIAG_W] = DIAG_W'(mat_ff[c][c]);
                  end
               end
            end
            OP_CLEAR: begin
               for (int r = 0; r < CHANNELS; r++) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     mat_in[r][i] = '0;
                  end
               end
               rel_in  = '0;
               relb_in = '0;
               wait_in = '0;
               reqb_in = '0;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < CHANNELS; r++) begin
            for (int i = 0; i < CHANNELS; i++) begin
               mat_ff[r][i] <= '0;
            end
         end
         rel_ff       <= '0;
         relb_ff      <= '0;
         wait_ff      <= '0;
         reqb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mat_ff       <= mat_in;
         rel_ff       <= rel_in;
         relb_ff      <= relb_in;
         wait_ff      <= wait_in;
         reqb_ff      <= reqb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      fresh_ff   <= fresh_in;
      filt_ff    <= filt_in;
      ch_ff      <= ch_in;
      pass_ff    <= pass_in;
      rsp_req_ff <= rsp_req_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_request_after = rsp_req_ff;
   assign rsp_own_counters  = rsp_cnt_ff;

endmodule

// ===== hw/rtl/cbs_seq.sv =====
module cbs_seq
   import cbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           start_clear,
   input  seq_status_type status,
   output seq_ctl_type    ctl
);

   logic           run_ff, run_in;
   step_type       step_ff, step_in;
   ucode_word_type cw;

   always_comb begin
      cw      = ucode_rom(step_ff);
      run_in  = run_ff;
      step_in = step_ff;
      if (!run_ff) begin
         if (start) begin
            run_in  = 1'b1;
            step_in = start_clear ? STEP_CLEAR : STEP_NEW;
         end
      end else begin
         case (cw.cond)
            COND_NEXT:    step_in = step_ff + 3'd1;
            COND_MORE_CH: step_in = status.more_ch ? cw.target : step_ff + 3'd1;
            COND_AGAIN:   step_in = status.again ? cw.target : step_ff + 3'd1;
            COND_JUMP:    step_in = cw.target;
            COND_END: begin
               // Hold on the output step until the result register can take the word.
               if (status.out_free) begin
                  run_in = 1'b0;
               end
            end
            default:      run_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= STEP_NEW;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   assign ctl.active = run_ff;
   assign ctl.op     = cw.op;

endmodule

// ===== test/channel_barrier_sync_top_tb.sv =====
`timescale 1ns / 100ps

module channel_barrier_sync_top_tb
   import cbs_pkg::*;
();

   localparam int CH           = DEF_CHANNELS;
   localparam int MOD          = DEF_COUNT_MODULUS;
   localparam int MASK_W       = CH * CH;
   localparam int DIAG_BITS    = DIAG_W * CH;
   localparam int RANDOM_WORDS = 500;
   localparam int PAUSE_AT     = 350;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 150;
   localparam int TAIL_CYCLES  = 60;
   localparam int WATCHDOG     = 2000;

   typedef struct {
      bit                   clr;
      logic [CH-1:0]        lv;
      logic [MASK_W-1:0]    fm;
      bit                   typed;
      logic [CH-1:0]        after;
      logic [DIAG_BITS-1:0] diag;
   } sync_row_type;

   typedef struct {
      logic [CH-1:0]        after;
      logic [DIAG_BITS-1:0] diag;
   } sync_result_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_clear_all = 1'b0;
   logic [CH-1:0]        req_request_levels = '0;
   logic [MASK_W-1:0]    req_filter_masks = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CH-1:0]        rsp_request_after;
   logic [DIAG_BITS-1:0] rsp_own_counters;

   // Typed expectation that travels with the word on the input port.
   bit                   word_typed = 1'b0;
   logic [CH-1:0]        word_after = '0;
   logic [DIAG_BITS-1:0] word_diag = '0;

   // Barrier state as seen by the predictor.
   logic [DIAG_W-1:0] sync_matrix [MASK_W];
   bit                done_now [CH];
   bit                done_prev [CH];
   bit                held [CH];
   bit                req_prev [CH];

   sync_result_type pending_sync [$];
   int              mismatches = 0;
   int              idle_cycles = 0;

   // Directed words: typed results only where they are obvious.
   sync_row_type directed [20] = '{
      '{1'b1, 3'b111, 9'h1FF, 1'b1, 3'b111, '0},
      '{1'b1, 3'b000, 9'h000, 1'b1, 3'b000, '0},
      '{1'b0, 3'b111, 9'h000, 1'b1, 3'b000, '0},
      '{1'b0, 3'b000, 9'h000, 1'b1, 3'b000, '0},
      '{1'b0, 3'b111, 9'h111, 1'b0, '0, '0},
      '{1'b0, 3'b000, 9'h111, 1'b0, '0, '0},
      '{1'b0, 3'b001, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b001, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b011, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b111, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b111, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b000, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b110, 9'h0C2, 1'b0, '0, '0},
      '{1'b0, 3'b111, 9'h0C2, 1'b0, '0, '0},
      '{1'b0, 3'b101, 9'h0A1, 1'b0, '0, '0},
      '{1'b0, 3'b000, 9'h1FF, 1'b0, '0, '0},
      '{1'b1, 3'b101, 9'h0AA, 1'b1, 3'b101, '0},
      '{1'b0, 3'b010, 9'h038, 1'b0, '0, '0},
      '{1'b0, 3'b111, 9'h1FF, 1'b0, '0, '0},
      '{1'b0, 3'b000, 9'h000, 1'b0, '0, '0}
   };

   channel_barrier_sync_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clear_all      (req_clear_all),
      .req_request_levels (req_request_levels),
      .req_filter_masks   (req_filter_masks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_request_after  (rsp_request_after),
      .rsp_own_counters   (rsp_own_counters)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < MASK_W; i++) sync_matrix[i] = '0;
      for (int c = 0; c < CH; c++) begin
         done_now[c]  = 1'b0;
         done_prev[c] = 1'b0;
         held[c]      = 1'b0;
         req_prev[c]  = 1'b0;
      end
   end

   function automatic logic [DIAG_W-1:0] bump_mod(input logic [DIAG_W-1:0] v);
      return DIAG_W'((int'(v) + 1) % MOD);
   endfunction

   // One scan tick of the barrier: a clear, or repeated channel passes (at most CH + 2) until no fresh release.
   task automatic advance_barrier(input logic clr, input logic [CH-1:0] lv,
                                  input logic [MASK_W-1:0] fm,
                                  output logic [CH-1:0] after,
                                  output logic [DIAG_BITS-1:0] diag);
      bit            rq [CH];
      bit            fresh [CH];
      logic [CH-1:0] flt [CH];
      bit            again;
      bit            ok;
      logic [DIAG_W-1:0] d;
      if (clr) begin
         for (int i = 0; i < MASK_W; i++) sync_matrix[i] = '0;
         for (int c = 0; c < CH; c++) begin
            done_now[c]  = 1'b0;
            done_prev[c] = 1'b0;
            held[c]      = 1'b0;
            req_prev[c]  = 1'b0;
         end
         after = lv;
         diag  = '0;
      end else begin
         for (int c = 0; c < CH; c++) begin
            flt[c]   = fm[CH*c +: CH];
            rq[c]    = lv[c] && (flt[c] != '0);
            fresh[c] = !held[c];
         end
         for (int pass = 0; pass < CH + 2; pass++) begin
            again = (pass == 0);
            for (int c = 0; c < CH; c++) begin
               held[c] = rq[c];
               if (rq[c]) begin
                  if (!req_prev[c]) begin
                     done_now[c] = 1'b0;
                     for (int i = 0; i < CH; i++)
                        sync_matrix[c*CH + i] = bump_mod(sync_matrix[i*CH + i]);
                  end
                  if (fresh[c]) begin
                     ok = 1'b1;
                     for (int i = 0; i < CH; i++)
                        if (i != c && flt[c][i] &&
                            sync_matrix[c*CH + i] != sync_matrix[i*CH + i])
                           ok = 1'b0;
                     if (ok) begin
                        done_now[c] = 1'b1;
                        if (!done_prev[c]) begin
                           d = bump_mod(sync_matrix[c*CH + c]);
                           for (int i = 0; i < CH; i++) sync_matrix[c*CH + i] = d;
                        end
                     end
                  end
               end
            end
            for (int c = 0; c < CH; c++) begin
               if (done_now[c]) rq[c] = 1'b0;
               req_prev[c] = rq[c];
               fresh[c]    = 1'b1;
               if (done_now[c] && !done_prev[c]) again = 1'b1;
               done_prev[c] = done_now[c];
            end
            if (!again) break;
         end
         for (int c = 0; c < CH; c++) begin
            after[c] = rq[c];
            diag[DIAG_W*c +: DIAG_W] = sync_matrix[c*CH + c];
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      logic [CH-1:0]        pa;
      logic [DIAG_BITS-1:0] pd;
      sync_result_type      want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_barrier(req_clear_all, req_request_levels, req_filter_masks, pa, pd);
            if (word_typed) begin
               pa = word_after;
               pd = word_diag;
            end
            pending_sync.push_back('{pa, pd});
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_sync.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: request_after %b own_counters %h",
                           rsp_request_after, rsp_own_counters);
            end else begin
               want = pending_sync.pop_front();
               if (want.after !== rsp_request_after || want.diag !== rsp_own_counters) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: request_after %b/%b own_counters %h/%h (exp/got)",
                              want.after, rsp_request_after, want.diag, rsp_own_counters);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG) @(posedge clock);
      $display("channel_barrier_sync_top_tb NOT OK");
      $finish;
   end

   // Result side: random hold-offs, one long hold, and a stretch without any.
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         else if (taken >= 200 && taken < 260) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   task automatic send_word(input bit clr, input logic [CH-1:0] lv,
                            input logic [MASK_W-1:0] fm, input bit no_gap,
                            input bit typed, input logic [CH-1:0] after,
                            input logic [DIAG_BITS-1:0] diag);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_clear_all      <= clr;
      req_request_levels <= lv;
      req_filter_masks   <= fm;
      word_typed         <= typed;
      word_after         <= after;
      word_diag          <= diag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      bit                clr;
      logic [CH-1:0]     lv;
      logic [MASK_W-1:0] fm;
      logic [CH-1:0]     cur_lv;
      logic [MASK_W-1:0] cur_fm;
      int                roll;
      int                toggle_max;
      cur_lv = '0;
      cur_fm = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[r])
         send_word(directed[r].clr, directed[r].lv, directed[r].fm, 1'b0,
                   directed[r].typed, directed[r].after, directed[r].diag);

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         roll = $urandom_range(0, 99);
         toggle_max = (k < RANDOM_WORDS / 2) ? 2 : 1;
         if (k < RANDOM_WORDS / 2 && roll < 3) begin
            clr = 1'b1;
            lv  = CH'($urandom);
            fm  = MASK_W'($urandom);
         end else if (roll < 12) begin
            clr = 1'b0;
            lv  = CH'($urandom);
            fm  = MASK_W'($urandom);
         end else begin
            // Requests that persist over several ticks, filters that change now and then.
            clr = 1'b0;
            for (int c = 0; c < CH; c++)
               if ($urandom_range(0, toggle_max) == 0) cur_lv[c] = ~cur_lv[c];
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0: cur_fm = MASK_W'($urandom);
                  1: cur_fm = '1;
                  2: cur_fm = 9'h111;
                  default: begin
                     for (int c = 0; c < CH; c++)
                        cur_fm[CH*c +: CH] = CH'($urandom_range(1, (1 << CH) - 1));
                  end
               endcase
            end
            // Late in the run channel 0 waits only on itself, so its diagonal wraps.
            if (k >= RANDOM_WORDS / 2) cur_fm[CH-1:0] = 3'b001;
            lv = cur_lv;
            fm = cur_fm;
         end
         send_word(clr, lv, fm, (k >= 100 && k < 160), 1'b0, '0, '0);
         if (k == PAUSE_AT) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_sync.size() != 0) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_sync.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("channel_barrier_sync_top_tb OK");
      else
         $display("channel_barrier_sync_top_tb NOT OK");
      $finish;
   end

endmodule
